// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication checked at every rising clock edge out of reset.
`define MIU_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked at every rising clock edge out of reset.
`define MIU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/miu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse package
// Widths, counter sizing and sequencer states for the modular inverse unit.
// ----------------------------------------------------------------------------
package miu_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

	typedef logic [WIDTH-1:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE,
		ST_REDUCE,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/core/modular_inverse_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse unit
// Extended Euclidean algorithm on a value and a modulus; one result per item.
// Each item runs one Euclid division step per nonzero remainder, until the
// remainder reaches zero. The next item can be taken in the cycle in which
// the result appears. The restoring divider produces one quotient bit per
// cycle and accumulates quotient times coefficient in the same pass; one
// division runs per Euclid step. The block takes a new item only when the
// sequencer is idle; a finished result sits in the output register until
// taken, while the next item may already enter.
// ----------------------------------------------------------------------------
module modular_inverse_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [miu_pkg::WIDTH-1:0] value,
	input  logic [miu_pkg::WIDTH-1:0] modulus,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [miu_pkg::WIDTH-1:0] inverse,
	output logic                     has_inverse,
	output logic [miu_pkg::WIDTH-1:0] common_divisor
);

	miu_pkg::state_t state_q, state_d;

	miu_pkg::word_t r0_q, r1_q, t0_q, t1_q, n_q;
	miu_pkg::word_t rem_q, quo_q, prod_q, m_q;
	logic           odd_q;
	logic [miu_pkg::CNT_W-1:0] cnt_q;

	miu_pkg::word_t inverse_q, gcd_q;
	logic           has_inv_q, out_valid_q;

	// Divider datapath: one restoring step per cycle.
	logic [miu_pkg::WIDTH:0] rem_shift, rem_diff;
	logic                    q_bit;
	miu_pkg::word_t          rem_next, prod_next;

	// Control decoded from the state.
	logic load_item, start_div, div_step, do_update, do_reduce, can_finish;

	// Result formation.
	miu_pkg::word_t red_diff, m_red, inv_calc;

	assign rem_shift = {rem_q, quo_q[miu_pkg::WIDTH-1]};
	assign rem_diff  = rem_shift - {1'b0, r1_q};
	assign q_bit     = ~rem_diff[miu_pkg::WIDTH];
	assign rem_next  = q_bit ? rem_diff[miu_pkg::WIDTH-1:0] : rem_shift[miu_pkg::WIDTH-1:0];
	// The product prefix never exceeds the final q * t1, which fits the word.
	assign prod_next = {prod_q[miu_pkg::WIDTH-2:0], 1'b0} + (q_bit ? t1_q : '0);

	assign red_diff = t0_q - n_q;
	assign m_red    = (t0_q >= n_q) ? red_diff : t0_q;

	always_comb begin
		if (r0_q != miu_pkg::word_t'(1) || n_q == '0) begin
			inv_calc = '0;
		end else if (odd_q && m_q != '0) begin
			inv_calc = n_q - m_q;
		end else begin
			inv_calc = m_q;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			miu_pkg::ST_IDLE: begin
				if (in_valid) state_d = miu_pkg::ST_CHECK;
			end
			miu_pkg::ST_CHECK: begin
				state_d = (r1_q == '0) ? miu_pkg::ST_REDUCE : miu_pkg::ST_DIV;
			end
			miu_pkg::ST_DIV: begin
				if (cnt_q == '0) state_d = miu_pkg::ST_UPDATE;
			end
			miu_pkg::ST_UPDATE: state_d = miu_pkg::ST_CHECK;
			miu_pkg::ST_REDUCE: state_d = miu_pkg::ST_FINISH;
			miu_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = miu_pkg::ST_IDLE;
			end
			default: state_d = miu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		load_item  = 1'b0;
		start_div  = 1'b0;
		div_step   = 1'b0;
		do_update  = 1'b0;
		do_reduce  = 1'b0;
		can_finish = 1'b0;
		case (state_q)
			miu_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				load_item = in_valid;
			end
			miu_pkg::ST_CHECK:  start_div  = (r1_q != '0);
			miu_pkg::ST_DIV:    div_step   = 1'b1;
			miu_pkg::ST_UPDATE: do_update  = 1'b1;
			miu_pkg::ST_REDUCE: do_reduce  = 1'b1;
			miu_pkg::ST_FINISH: can_finish = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= miu_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (can_finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (start_div) begin
				cnt_q <= miu_pkg::CNT_LAST;
			end else if (div_step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			r0_q  <= value;
			r1_q  <= modulus;
			n_q   <= modulus;
			t0_q  <= miu_pkg::word_t'(1);
			t1_q  <= '0;
			odd_q <= 1'b0;
		end
		if (start_div) begin
			rem_q  <= '0;
			quo_q  <= r0_q;
			prod_q <= '0;
		end
		if (div_step) begin
			rem_q  <= rem_next;
			quo_q  <= {quo_q[miu_pkg::WIDTH-2:0], q_bit};
			prod_q <= prod_next;
		end
		if (do_update) begin
			r0_q  <= r1_q;
			r1_q  <= rem_q;
			t0_q  <= t1_q;
			t1_q  <= t0_q + prod_q;
			odd_q <= ~odd_q;
		end
		if (do_reduce) begin
			m_q <= m_red;
		end
		if (can_finish) begin
			inverse_q <= inv_calc;
			gcd_q     <= r0_q;
			has_inv_q <= (r0_q == miu_pkg::word_t'(1));
		end
	end

	assign out_valid      = out_valid_q;
	assign inverse        = inverse_q;
	assign has_inverse    = has_inv_q;
	assign common_divisor = gcd_q;

endmodule

// ===== rtl/core/miu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular inverse checker
// Port-level assertions for the modular inverse unit, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module miu_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [miu_pkg::WIDTH-1:0] inverse,
	input logic                      has_inverse,
	input logic [miu_pkg::WIDTH-1:0] common_divisor
);

	logic                      stalled;
	logic                      accepted;
	logic                      no_flag;
	logic                      gcd_is_one;
	logic [2*miu_pkg::WIDTH:0] result_bits;

	assign stalled     = out_valid && !out_ready;
	assign accepted    = in_valid && in_ready;
	assign no_flag     = out_valid && !has_inverse;
	assign gcd_is_one  = (common_divisor == miu_pkg::word_t'(1));
	assign result_bits = {inverse, has_inverse, common_divisor};

	`MIU_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid, "result dropped")
	`MIU_ASSERT_NEXT(a_out_stable, clk, arst_n, stalled, $stable(result_bits), "result changed")
	`MIU_ASSERT_SAME(a_flag_gcd, clk, arst_n, out_valid, has_inverse == gcd_is_one, "flag disagrees")
	`MIU_ASSERT_SAME(a_no_inv_zero, clk, arst_n, no_flag, inverse == '0, "inverse without flag")
	`MIU_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accepted, !in_ready, "taken while busy")

endmodule

bind modular_inverse_unit miu_checker u_miu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.inverse        (inverse),
	.has_inverse    (has_inverse),
	.common_divisor (common_divisor)
);
